### rtl/pdd_pkg.sv
// Shared types and constants for the differential drive PID controller.
package pdd_pkg;

    // Operating modes held in the drive_mode register.
    typedef enum logic [1:0] {
        MODE_STOP     = 2'd0,
        MODE_FOLLOW   = 2'd1,
        MODE_STRAIGHT = 2'd2
    } t_mode;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_LEFT   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_RIGHT  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_DRIVE_MODE  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_LINE_CENTER = 3'd6;

    // Register reset values.
    localparam logic [15:0] RST_GAIN_P      = 16'd64;
    localparam logic [15:0] RST_GAIN_I      = 16'd0;
    localparam logic [15:0] RST_GAIN_D      = 16'd0;
    localparam logic [7:0]  RST_BASE_LEFT   = 8'd80;
    localparam logic [7:0]  RST_BASE_RIGHT  = 8'd80;
    localparam logic [11:0] RST_LINE_CENTER = 12'd2000;

    // Output limits.
    localparam int CORR_MAX       = 100;
    localparam int CORR_MIN       = -100;
    localparam int SPEED_MAX      = 255;
    localparam logic [7:0] STRAIGHT_SPEED = 8'd50;

    // One result item.
    typedef struct packed {
        logic              drive_enable;
        logic signed [7:0] correction;
        logic [7:0]        right_speed;
        logic [7:0]        left_speed;
    } t_result;

endpackage

### rtl/pid_differential_drive.sv
// Top level of the PID line follower for a differential drive robot.
//
// Each request on the slave stream is one control tick carrying the weighted
// line position; each tick yields exactly one request on the master stream
// with the left and right motor duties, the clamped correction and the drive
// enable. The block is a four stage pipeline: the first stage forms the error,
// the derivative and the saturated integral (the integral and the previous
// error update as the tick is taken), the second forms the three gain
// products, the third adds them, and the fourth scales, clamps and registers
// the result. While the output does not stall, a tick enters in every cycle,
// so the sustained rate is one tick per clock. A tick passes through r1, r2,
// r3 and the output register in order; a stalled output holds its result, a
// stage moves on only where a later stage has room, and the input stalls
// once all four stages are full. The integral product uses two multipliers,
// one per half of the integral. Stop mode (and the unused mode code) gives
// zero speeds with the drive off, straight mode gives both speeds of 50; in
// both, the integral and previous error hold.
// Configuration writes are always accepted; an unknown index is ignored.
module pid_differential_drive #(
    parameter int GAIN_FRAC_BITS = 8,
    parameter int SUM_WIDTH      = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pdd_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [15:0]                    i_cfg_data,

    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] line_position, [15:12] zero

    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] left_speed, [15:8] right_speed, [23:16] correction,
    // [24] drive_enable, [31:25] zero
    output logic [31:0] m_axis_tdata
);

    localparam int LO_W   = SUM_WIDTH / 2;          // low half of the integral
    localparam int HI_W   = SUM_WIDTH - LO_W;       // signed high half
    localparam int P_W    = 16 + 13;
    localparam int D_W    = 16 + 14;
    localparam int IHI_W  = 16 + HI_W;
    localparam int ILO_W  = 16 + LO_W + 1;
    localparam int ACC_W  = SUM_WIDTH + 17;

    // Configuration registers.
    logic signed [15:0] r_gain_p;
    logic signed [15:0] r_gain_i;
    logic signed [15:0] r_gain_d;
    logic [7:0]         r_base_left;
    logic [7:0]         r_base_right;
    pdd_pkg::t_mode     r_drive_mode;
    logic [11:0]        r_line_center;

    // Controller state.
    logic signed [SUM_WIDTH-1:0] r_error_sum;
    logic signed [12:0]          r_last_error;

    // Pipeline registers.
    logic                        r1_valid;
    pdd_pkg::t_mode              r1_mode;
    logic signed [12:0]          r1_err;
    logic signed [13:0]          r1_deriv;
    logic signed [SUM_WIDTH-1:0] r1_sum;

    logic                        r2_valid;
    pdd_pkg::t_mode              r2_mode;
    logic signed [P_W-1:0]       r2_p;
    logic signed [D_W-1:0]       r2_d;
    logic signed [IHI_W-1:0]     r2_ihi;
    logic signed [ILO_W-1:0]     r2_ilo;

    logic                        r3_valid;
    pdd_pkg::t_mode              r3_mode;
    logic signed [ACC_W-1:0]     r3_acc;

    logic                        r_out_valid;
    pdd_pkg::t_result            r_out;

    // Next values and handshake terms.
    logic                        in_take;
    logic                        out_free;
    logic                        en2;
    logic                        en1;
    logic signed [12:0]          n_err;
    logic signed [13:0]          n_deriv;
    logic signed [SUM_WIDTH:0]   sum_wide;
    logic signed [SUM_WIDTH-1:0] n_sum;
    logic signed [P_W-1:0]       n_p;
    logic signed [D_W-1:0]       n_d;
    logic signed [IHI_W-1:0]     n_ihi;
    logic signed [ILO_W-1:0]     n_ilo;
    logic signed [HI_W-1:0]      sum_hi;
    logic signed [LO_W:0]        sum_lo;
    logic signed [ACC_W-1:0]     n_acc;
    pdd_pkg::t_result            n_out;

    // Each stage loads when it is empty or its contents move on.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign en2           = !r3_valid || out_free;
    assign en1           = !r2_valid || en2;
    assign s_axis_tready = !r1_valid || en1;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p      <= pdd_pkg::RST_GAIN_P;
            r_gain_i      <= pdd_pkg::RST_GAIN_I;
            r_gain_d      <= pdd_pkg::RST_GAIN_D;
            r_base_left   <= pdd_pkg::RST_BASE_LEFT;
            r_base_right  <= pdd_pkg::RST_BASE_RIGHT;
            r_drive_mode  <= pdd_pkg::MODE_FOLLOW;
            r_line_center <= pdd_pkg::RST_LINE_CENTER;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                pdd_pkg::REG_GAIN_P:      r_gain_p      <= i_cfg_data;
                pdd_pkg::REG_GAIN_I:      r_gain_i      <= i_cfg_data;
                pdd_pkg::REG_GAIN_D:      r_gain_d      <= i_cfg_data;
                pdd_pkg::REG_BASE_LEFT:   r_base_left   <= i_cfg_data[7:0];
                pdd_pkg::REG_BASE_RIGHT:  r_base_right  <= i_cfg_data[7:0];
                pdd_pkg::REG_DRIVE_MODE:  r_drive_mode  <= pdd_pkg::t_mode'(i_cfg_data[1:0]);
                pdd_pkg::REG_LINE_CENTER: r_line_center <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    // Stage one: error, derivative and saturating integral.
    assign n_err    = $signed({1'b0, s_axis_tdata[11:0]}) - $signed({1'b0, r_line_center});
    assign n_deriv  = 14'(n_err) - 14'(r_last_error);
    assign sum_wide = (SUM_WIDTH+1)'(r_error_sum) + (SUM_WIDTH+1)'(n_err);

    always_comb begin
        if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
            // Overflowed: pin to the limit on the side of the true sign.
            n_sum = {sum_wide[SUM_WIDTH], {(SUM_WIDTH-1){!sum_wide[SUM_WIDTH]}}};
        end else begin
            n_sum = sum_wide[SUM_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum  <= '0;
            r_last_error <= '0;
        end else if (in_take && r_drive_mode == pdd_pkg::MODE_FOLLOW) begin
            r_error_sum  <= n_sum;
            r_last_error <= n_err;
        end
    end

    // Stage two: gain products, the integral product in two halves.
    assign sum_hi = r1_sum[SUM_WIDTH-1:LO_W];
    assign sum_lo = $signed({1'b0, r1_sum[LO_W-1:0]});
    assign n_p    = r_gain_p * r1_err;
    assign n_d    = r_gain_d * r1_deriv;
    assign n_ihi  = r_gain_i * sum_hi;
    assign n_ilo  = r_gain_i * sum_lo;

    // Stage three: one sum of all terms.
    assign n_acc = (ACC_W'(r2_ihi) <<< LO_W) + ACC_W'(r2_ilo) + ACC_W'(r2_p) + ACC_W'(r2_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r1_valid <= s_axis_tvalid;
            end
            if (en1) begin
                r2_valid <= r1_valid;
            end
            if (en2) begin
                r3_valid <= r2_valid;
            end
            if (out_free) begin
                r_out_valid <= r3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r1_mode  <= r_drive_mode;
            r1_err   <= n_err;
            r1_deriv <= n_deriv;
            r1_sum   <= n_sum;
        end
        if (en1) begin
            r2_mode <= r1_mode;
            r2_p    <= n_p;
            r2_d    <= n_d;
            r2_ihi  <= n_ihi;
            r2_ilo  <= n_ilo;
        end
        if (en2) begin
            r3_mode <= r2_mode;
            r3_acc  <= n_acc;
        end
        if (out_free) begin
            r_out <= n_out;
        end
    end

    // Stage four: scaling, clamping and mode selection.
    pdd_output #(
        .ACC_WIDTH      (ACC_W),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_output (
        .i_acc        (r3_acc),
        .i_mode       (r3_mode),
        .i_base_left  (r_base_left),
        .i_base_right (r_base_right),
        .o_result     (n_out)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out};

endmodule

### rtl/pdd_output.sv
// Output law: scale the PID sum, clamp the correction and form both motor speeds.
module pdd_output #(
    parameter int ACC_WIDTH      = 49,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic signed [ACC_WIDTH-1:0] i_acc,
    input  pdd_pkg::t_mode              i_mode,
    input  logic [7:0]                  i_base_left,
    input  logic [7:0]                  i_base_right,
    output pdd_pkg::t_result            o_result
);

    logic signed [ACC_WIDTH-1:0] bias;
    logic signed [ACC_WIDTH-1:0] scaled;
    logic signed [7:0]           corr;
    logic signed [9:0]           left_raw;
    logic signed [9:0]           right_raw;
    logic [7:0]                  left_sat;
    logic [7:0]                  right_sat;

    // Arithmetic shift rounds toward minus infinity; a bias on negative sums
    // turns it into truncation toward zero.
    assign bias   = i_acc[ACC_WIDTH-1]
                  ? ((ACC_WIDTH'(1) <<< GAIN_FRAC_BITS) - ACC_WIDTH'(1))
                  : '0;
    assign scaled = (i_acc + bias) >>> GAIN_FRAC_BITS;

    always_comb begin
        if (scaled > ACC_WIDTH'(pdd_pkg::CORR_MAX)) begin
            corr = 8'(pdd_pkg::CORR_MAX);
        end else if (scaled < ACC_WIDTH'(pdd_pkg::CORR_MIN)) begin
            corr = 8'(pdd_pkg::CORR_MIN);
        end else begin
            corr = scaled[7:0];
        end
    end

    assign left_raw  = $signed({2'b00, i_base_left}) + 10'(corr);
    assign right_raw = $signed({2'b00, i_base_right}) - 10'(corr);

    always_comb begin
        if (left_raw < 10'sd0) begin
            left_sat = 8'd0;
        end else if (left_raw > 10'(pdd_pkg::SPEED_MAX)) begin
            left_sat = 8'(pdd_pkg::SPEED_MAX);
        end else begin
            left_sat = left_raw[7:0];
        end
        if (right_raw < 10'sd0) begin
            right_sat = 8'd0;
        end else if (right_raw > 10'(pdd_pkg::SPEED_MAX)) begin
            right_sat = 8'(pdd_pkg::SPEED_MAX);
        end else begin
            right_sat = right_raw[7:0];
        end
    end

    always_comb begin
        unique case (i_mode)
            pdd_pkg::MODE_FOLLOW: begin
                o_result.left_speed   = left_sat;
                o_result.right_speed  = right_sat;
                o_result.correction   = corr;
                o_result.drive_enable = 1'b1;
            end
            pdd_pkg::MODE_STRAIGHT: begin
                o_result.left_speed   = pdd_pkg::STRAIGHT_SPEED;
                o_result.right_speed  = pdd_pkg::STRAIGHT_SPEED;
                o_result.correction   = '0;
                o_result.drive_enable = 1'b1;
            end
            default: begin
                o_result.left_speed   = '0;
                o_result.right_speed  = '0;
                o_result.correction   = '0;
                o_result.drive_enable = 1'b0;
            end
        endcase
    end

endmodule
